@@ rtl/pffl_pkg.sv @@
// Package for the page frame free list allocator.
// Holds shared widths, limits, payload structs and controller/datapath links.
// No dependencies.
`default_nettype none

package pffl_pkg;

  localparam int MaxFrames  = 1024;
  localparam int MaxRequest = 32;
  localparam int FrameW     = $clog2(MaxFrames);
  localparam int TotalW     = $clog2(MaxFrames + 1);
  localparam int CountW     = $clog2(MaxRequest + 1);

  typedef struct packed {
    logic              mode;
    logic [CountW-1:0] count;
    logic [FrameW-1:0] frame;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic              frame_valid;
    logic [FrameW-1:0] frame_out;
    logic              last;
    logic [TotalW-1:0] free_count;
  } rsp_t;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct packed {
    logic cfg_write;
    logic latch;
    logic clr_step;
    logic emit_fail;
    logic emit_zero;
    logic do_free;
    logic pop_first;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic alloc_bad;
    logic alloc_zero;
    logic free_bad;
    logic rem_one;
    logic clr_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/page_frame_free_list_allocator_top.sv @@
// Page frame free list allocator: LIFO free list of frame numbers kept in
// a 1024-entry link store. After reset, and after every write of the frame
// total, the block is busy for a clear sweep that rebuilds the chain.
// A request is taken when start is high and busy low. An allocate of n frames
// that succeeds passes through a decision state and n pop states and returns
// n results on consecutive cycles, one frame per cycle, limited by the link
// store's single read port as each pop reads the link of the frame it removes.
// Failed or zero-frame allocates and frees take only the decision state and
// return one result. Each result is held for one cycle with result_valid and
// cannot be stalled. Depends on pffl_pkg, pffl_ctrl and pffl_dp.
`default_nettype none

module page_frame_free_list_allocator_top
  import pffl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              req,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TotalW-1:0] cfg_data,
  output logic                   result_valid,
  output rsp_t                   result
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pffl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pffl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req          (req),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ rtl/pffl_dp.sv @@
// Datapath: link store, head pointer, free counter, clear sweep and result register.
// Depends on pffl_pkg; driven by pffl_ctrl through ctrl_cmd_t.
`default_nettype none

module pffl_dp
  import pffl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         cmd,
  output ctrl_sts_t              sts,
  input  wire req_t              req,
  input  wire logic [TotalW-1:0] cfg_data,
  output logic                   result_valid,
  output rsp_t                   result
);

  logic [FrameW-1:0] mem [MaxFrames];
  logic [FrameW-1:0] rdata;
  logic [FrameW-1:0] rd_addr;
  logic [FrameW-1:0] head;
  logic [TotalW-1:0] free_cnt;
  logic [TotalW-1:0] total;
  logic [TotalW-1:0] total_next;
  logic [FrameW-1:0] clr_idx;
  logic [CountW-1:0] rem;
  req_t              req_q;

  always_comb begin
    total_next = cfg_data;
    if (cfg_data == '0) begin
      total_next = TotalW'(1);
    end else if (cfg_data > TotalW'(MaxFrames)) begin
      total_next = TotalW'(MaxFrames);
    end
  end

  assign rd_addr = cmd.pop ? rdata : head;

  assign sts.mode       = req_q.mode;
  assign sts.alloc_bad  = (req_q.count > CountW'(MaxRequest))
                          || (TotalW'(req_q.count) > free_cnt);
  assign sts.alloc_zero = (req_q.count == '0);
  assign sts.free_bad   = (free_cnt >= total) || (TotalW'(req_q.frame) >= total);
  assign sts.rem_one    = (rem == CountW'(1));
  assign sts.clr_last   = (clr_idx == FrameW'(MaxFrames - 1));

  // link store: one write port (sweep or push), one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_idx] <= clr_idx + FrameW'(1);
    end else if (cmd.do_free) begin
      mem[req_q.frame] <= head;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= TotalW'(MaxFrames);
      free_cnt     <= TotalW'(MaxFrames);
      head         <= '0;
      clr_idx      <= '0;
      rem          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_fail || cmd.emit_zero || cmd.do_free || cmd.pop;
      if (cmd.cfg_write) begin
        total    <= total_next;
        free_cnt <= total_next;
        head     <= '0;
        clr_idx  <= '0;
      end
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + FrameW'(1);
      end
      if (cmd.do_free) begin
        head     <= req_q.frame;
        free_cnt <= free_cnt + TotalW'(1);
      end
      if (cmd.pop_first) begin
        rem <= req_q.count;
      end
      if (cmd.pop) begin
        head     <= rdata;
        free_cnt <= free_cnt - TotalW'(1);
        rem      <= rem - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req;
    end
    if (cmd.emit_fail || cmd.emit_zero) begin
      result.ok          <= cmd.emit_zero;
      result.frame_valid <= 1'b0;
      result.frame_out   <= '0;
      result.last        <= 1'b1;
      result.free_count  <= free_cnt;
    end else if (cmd.do_free) begin
      result.ok          <= 1'b1;
      result.frame_valid <= 1'b0;
      result.frame_out   <= '0;
      result.last        <= 1'b1;
      result.free_count  <= free_cnt + TotalW'(1);
    end else if (cmd.pop) begin
      result.ok          <= 1'b1;
      result.frame_valid <= 1'b1;
      result.frame_out   <= head;
      result.last        <= sts.rem_one;
      result.free_count  <= free_cnt - TotalW'(1);
    end
  end

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= total)
    else $error("free count above frame total");

  a_pop_has_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (free_cnt != '0) && (rem != '0))
    else $error("pop with empty list or no frames left to take");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> result_valid && result.frame_valid && result.ok)
    else $error("pop did not produce a frame result");

endmodule

`default_nettype wire

@@ rtl/pffl_ctrl.sv @@
// Controller state machine: accepts requests and config writes, sequences
// the clear sweep, decision and pops. Depends on pffl_pkg.
`default_nettype none

module pffl_ctrl
  import pffl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    DECIDE = 4'b0010,
    POP    = 4'b0100,
    CLEAR  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   cfg_we;

  assign busy      = (state != IDLE);
  assign cfg_ready = (state == CLEAR) || ((state == IDLE) && !start);
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (cfg_we) begin
          cmd.cfg_write = 1'b1;
          state_next    = CLEAR;
        end else if (start) begin
          cmd.latch  = 1'b1;
          state_next = DECIDE;
        end
      end
      CLEAR: begin
        if (cfg_we) begin
          cmd.cfg_write = 1'b1;
        end else begin
          cmd.clr_step = 1'b1;
          if (sts.clr_last) begin
            state_next = IDLE;
          end
        end
      end
      DECIDE: begin
        state_next = IDLE;
        if (sts.mode == ModeAlloc) begin
          if (sts.alloc_bad) begin
            cmd.emit_fail = 1'b1;
          end else if (sts.alloc_zero) begin
            cmd.emit_zero = 1'b1;
          end else begin
            cmd.pop_first = 1'b1;
            state_next    = POP;
          end
        end else if (sts.free_bad) begin
          cmd.emit_fail = 1'b1;
        end else begin
          cmd.do_free = 1'b1;
        end
      end
      POP: begin
        cmd.pop = 1'b1;
        if (sts.rem_one) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_fail, cmd.emit_zero, cmd.do_free, cmd.pop_first,
              cmd.pop, cmd.clr_step, cmd.cfg_write, cmd.latch}))
    else $error("more than one datapath action in a cycle");

  a_pop_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_first |=> cmd.pop)
    else $error("allocation decision not followed by a pop");

  a_start_taken: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == DECIDE)
    else $error("accepted transaction did not reach the decision state");

endmodule

`default_nettype wire
